// ===== rtl/smooth_teager_kaiser_energy_assert.svh =====
// assertion macros, included by the rtl back end stke_back
`ifndef SMOOTH_TEAGER_KAISER_ENERGY_ASSERT_SVH
`define SMOOTH_TEAGER_KAISER_ENERGY_ASSERT_SVH
`ifndef SYNTHESIS
`define STKE_ASSERT_IMPLIES(name, clk_sig, rst_sig, cond, conseq) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond) |-> (conseq)) \
    else $error("stke assertion failed");
`define STKE_ASSERT_NEXT(name, clk_sig, rst_sig, cond, conseq) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond) |=> (conseq)) \
    else $error("stke assertion failed");
`else
`define STKE_ASSERT_IMPLIES(name, clk_sig, rst_sig, cond, conseq)
`define STKE_ASSERT_NEXT(name, clk_sig, rst_sig, cond, conseq)
`endif
`endif

// ===== rtl/stke_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package stke_pkg;
  localparam int WIN_LEN     = 11;
  localparam int HALF_WIN    = 5;
  localparam int TAIL_CNT    = 6;
  localparam int STEP_BITS   = 13;
  localparam int ENERGY_BITS = 52;
  localparam int QUEUE_DEPTH = 4;
  localparam int POS_BITS    = 4;
  localparam int POS_FULL    = 10;
  localparam int LEAD_BITS   = 3;
  localparam int SEL_BITS    = 3;
  localparam logic [LEAD_BITS-1:0] LEAD_NONE = 3'd5;

  typedef enum logic [1:0] {
    KIND_RUN,
    KIND_TAIL,
    KIND_SHORT
  } kind_t;

  // control half of a queued job
  typedef struct packed {
    kind_t                 kind;
    logic [LEAD_BITS-1:0]  lead;
    logic [TAIL_CNT-1:0]   hits;
  } job_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/stke_sample_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface stke_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          frame_end;

  modport source (output valid, output sample, output frame_end, input ready);
  modport sink (input valid, input sample, input frame_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/stke_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface stke_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [stke_pkg::STEP_BITS-1:0] decimation_step;

  modport source (output valid, output decimation_step, input ready);
  modport sink (input valid, input decimation_step, output ready);
endinterface
`default_nettype wire

// ===== rtl/stke_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface stke_result_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [stke_pkg::ENERGY_BITS-1:0] energy;
  logic                                    last_result;
  logic                                    short_frame;

  modport source (output valid, output energy, output last_result, output short_frame,
                  input ready);
  modport sink (input valid, input energy, input last_result, input short_frame,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/stke_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module stke_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_STEP    = 4096
) (
  input  logic                                                 clk,
  input  logic                                                 rst,
  stke_sample_if.sink                                          feed,
  stke_cfg_if.sink                                             cfg,
  input  logic                                                 q_full,
  output logic                                                 push,
  output stke_pkg::job_ctl_t                                   push_ctl,
  output logic [stke_pkg::WIN_LEN-1:0][SAMPLE_BITS-1:0]        push_win
);
  localparam int SB_EXT = $clog2(MAX_STEP + 1);
  localparam int EW = (SB_EXT > stke_pkg::STEP_BITS) ? SB_EXT : stke_pkg::STEP_BITS;
  localparam int PW = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 1;

  logic [stke_pkg::STEP_BITS-1:0]                step_reg;
  logic [EW-1:0]                                 step_eff;
  logic [PW-1:0]                                 phase;
  logic [PW-1:0]                                 ph [stke_pkg::TAIL_CNT+1];
  logic [stke_pkg::TAIL_CNT-1:0]                 hit;
  logic [stke_pkg::TAIL_CNT-1:0]                 hits;
  logic [stke_pkg::POS_BITS-1:0]                 pos;
  logic [stke_pkg::WIN_LEN-1:0][SAMPLE_BITS-1:0] win;
  logic [stke_pkg::WIN_LEN-1:0][SAMPLE_BITS-1:0] win_shift;
  logic                                          accept;
  logic                                          is_short;
  logic                                          is_tail;
  logic                                          centre_due;

  assign cfg.ready  = 1'b1;
  assign feed.ready = !q_full;
  assign accept     = feed.valid && feed.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_reg <= stke_pkg::STEP_BITS'(1);
    end else if (cfg.valid) begin
      step_reg <= cfg.decimation_step;
    end
  end

  // zero acts as one, oversize clamps
  always_comb begin
    if (step_reg == '0) begin
      step_eff = EW'(1);
    end else if (EW'(step_reg) > EW'(MAX_STEP)) begin
      step_eff = EW'(MAX_STEP);
    end else begin
      step_eff = EW'(step_reg);
    end
  end

  // phase chain over the centres a frame end can flush
  always_comb begin
    ph[0] = phase;
    for (int j = 0; j < stke_pkg::TAIL_CNT; j++) begin
      hit[j] = (ph[j] == '0);
      if ((EW'(ph[j]) + EW'(1)) >= step_eff) begin
        ph[j+1] = '0;
      end else begin
        ph[j+1] = ph[j] + PW'(1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < stke_pkg::WIN_LEN - 1; i++) begin
      win_shift[i] = win[i+1];
    end
    win_shift[stke_pkg::WIN_LEN-1] = feed.sample;
  end

  assign is_short   = feed.frame_end && (pos < stke_pkg::POS_BITS'(stke_pkg::POS_FULL));
  assign is_tail    = feed.frame_end && !is_short;
  assign centre_due = (pos >= stke_pkg::POS_BITS'(stke_pkg::HALF_WIN));

  always_comb begin
    if (is_tail) begin
      hits = hit;
    end else if (!is_short && centre_due) begin
      hits = {{(stke_pkg::TAIL_CNT-1){1'b0}}, hit[0]};
    end else begin
      hits = '0;
    end
  end

  always_comb begin
    if (is_short) begin
      push_ctl.kind = stke_pkg::KIND_SHORT;
    end else if (is_tail) begin
      push_ctl.kind = stke_pkg::KIND_TAIL;
    end else begin
      push_ctl.kind = stke_pkg::KIND_RUN;
    end
    if (centre_due && (pos < stke_pkg::POS_BITS'(stke_pkg::POS_FULL))) begin
      push_ctl.lead = stke_pkg::LEAD_BITS'(pos - stke_pkg::POS_BITS'(stke_pkg::HALF_WIN));
    end else begin
      push_ctl.lead = stke_pkg::LEAD_NONE;
    end
    push_ctl.hits = hits;
  end

  assign push     = accept && (is_short || (hits != '0));
  assign push_win = win_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      win   <= '0;
      pos   <= '0;
      phase <= '0;
    end else if (accept) begin
      if (feed.frame_end) begin
        win   <= '0;
        pos   <= '0;
        phase <= '0;
      end else begin
        win <= win_shift;
        if (pos != stke_pkg::POS_BITS'(stke_pkg::POS_FULL)) begin
          pos <= pos + stke_pkg::POS_BITS'(1);
        end
        if (centre_due) begin
          phase <= ph[1];
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/stke_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module stke_queue #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);
  localparam int AW = $clog2(stke_pkg::QUEUE_DEPTH);

  logic [WIDTH-1:0] mem [stke_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;

  assign full       = (count == (AW+1)'(stke_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/stke_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "smooth_teager_kaiser_energy_assert.svh"
module stke_back #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          head_valid,
  input  stke_pkg::job_ctl_t                            head_ctl,
  input  logic [stke_pkg::WIN_LEN-1:0][SAMPLE_BITS-1:0] head_win,
  output logic                                          pop,
  stke_result_if.source                                 result
);
  localparam int S1W = SAMPLE_BITS + 8;
  localparam int S2W = SAMPLE_BITS + 9;
  localparam int EB  = stke_pkg::ENERGY_BITS;
  localparam int TW  = 5;

  logic [stke_pkg::TAIL_CNT-1:0]  done;
  logic [stke_pkg::TAIL_CNT-1:0]  remaining;
  logic [stke_pkg::TAIL_CNT-1:0]  sel_mask;
  logic [stke_pkg::TAIL_CNT-1:0]  left_after;
  logic [stke_pkg::SEL_BITS-1:0]  sel;
  logic                           issue;
  logic                           issue_last;
  logic                           head_short;
  logic [3:0]                     tap_idx [stke_pkg::WIN_LEN];
  logic signed [SAMPLE_BITS-1:0]  view [stke_pkg::WIN_LEN];

  logic                           v_valid, v_last, v_short, v_ready;
  logic signed [SAMPLE_BITS-1:0]  v_tap [stke_pkg::WIN_LEN];
  logic signed [S1W-1:0]          d [stke_pkg::HALF_WIN];
  logic signed [S2W-1:0]          e [stke_pkg::HALF_WIN];

  logic                           s_valid, s_last, s_short, s_ready;
  logic signed [S1W-1:0]          s1;
  logic signed [S2W-1:0]          s2;
  logic signed [SAMPLE_BITS-1:0]  s_xc;

  logic                           p_valid, p_last, p_short, p_ready;
  logic signed [2*S1W-1:0]        p_sq;
  logic signed [SAMPLE_BITS+S2W-1:0] p_cross;

  logic                           o_valid, o_last, o_short, o_ready;
  logic signed [EB-1:0]           o_energy;
  logic signed [EB-1:0]           sq_e, cross_e, energy_next;

  // lowest pending centre of the head job
  always_comb begin
    remaining = head_ctl.hits & ~done;
    sel       = '0;
    for (int j = stke_pkg::TAIL_CNT - 1; j >= 0; j--) begin
      if (remaining[j]) begin
        sel = stke_pkg::SEL_BITS'(j);
      end
    end
    sel_mask   = stke_pkg::TAIL_CNT'(1) << sel;
    left_after = remaining & ~sel_mask;
  end

  assign head_short = (head_ctl.kind == stke_pkg::KIND_SHORT);
  assign issue      = head_valid && v_ready;
  assign pop        = issue && (head_short || (left_after == '0));
  assign issue_last = head_short || ((head_ctl.kind == stke_pkg::KIND_TAIL) &&
                                     (left_after == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else if (pop) begin
      done <= '0;
    end else if (issue) begin
      done <= done | sel_mask;
    end
  end

  // mirrored tap selection: tail end folds past the newest sample,
  // frame start folds below sample zero
  always_comb begin
    for (int k = 0; k < stke_pkg::WIN_LEN; k++) begin
      if (head_ctl.kind == stke_pkg::KIND_TAIL) begin
        if ((TW'(sel) + TW'(k)) <= TW'(stke_pkg::WIN_LEN - 1)) begin
          tap_idx[k] = 4'(TW'(sel) + TW'(k));
        end else begin
          tap_idx[k] = 4'(TW'(2 * stke_pkg::WIN_LEN - 1) - TW'(sel) - TW'(k));
        end
      end else if ((head_ctl.lead != stke_pkg::LEAD_NONE) &&
                   ((TW'(k) + TW'(head_ctl.lead)) < TW'(stke_pkg::HALF_WIN))) begin
        tap_idx[k] = 4'(TW'(2 * stke_pkg::HALF_WIN - 1) - TW'({head_ctl.lead, 1'b0})
                        - TW'(k));
      end else begin
        tap_idx[k] = 4'(k);
      end
      view[k] = $signed(head_win[tap_idx[k]]);
    end
  end

  assign v_ready = !v_valid || s_ready;
  assign s_ready = !s_valid || p_ready;
  assign p_ready = !p_valid || o_ready;
  assign o_ready = !o_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_valid <= 1'b0;
      s_valid <= 1'b0;
      p_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (v_ready) begin
        v_valid <= issue;
      end
      if (s_ready) begin
        s_valid <= v_valid;
      end
      if (p_ready) begin
        p_valid <= s_valid;
      end
      if (o_ready) begin
        o_valid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v_ready && issue) begin
      v_tap   <= view;
      v_last  <= issue_last;
      v_short <= head_short;
    end
  end

  // symmetric pairs of the two differentiators
  always_comb begin
    for (int k = 0; k < stke_pkg::HALF_WIN; k++) begin
      d[k] = S1W'(v_tap[stke_pkg::WIN_LEN-1-k]) - S1W'(v_tap[k]);
      e[k] = S2W'(v_tap[stke_pkg::WIN_LEN-1-k]) + S2W'(v_tap[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && v_valid) begin
      s1 <= S1W'(d[0] + d[1] * 8 + d[2] * 27 + d[3] * 48 + d[4] * 42);
      s2 <= S2W'(e[1] * (-7) + e[2] * 12 + e[3] * 52 + e[4] * (-12)
                 + S2W'(v_tap[stke_pkg::HALF_WIN]) * (-90));
      s_xc    <= v_tap[stke_pkg::HALF_WIN];
      s_last  <= v_last;
      s_short <= v_short;
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready && s_valid) begin
      p_sq    <= s1 * s1;
      p_cross <= s_xc * s2;
      p_last  <= s_last;
      p_short <= s_short;
    end
  end

  // 3*S1^2 - 4096*x*S2, wrapped to the energy width
  assign sq_e        = EB'(p_sq);
  assign cross_e     = EB'(p_cross);
  assign energy_next = sq_e + (sq_e <<< 1) - (cross_e <<< 12);

  always_ff @(posedge clk) begin
    if (o_ready && p_valid) begin
      o_energy <= p_short ? '0 : energy_next;
      o_last   <= p_last;
      o_short  <= p_short;
    end
  end

  assign result.valid       = o_valid;
  assign result.energy      = o_energy;
  assign result.last_result = o_last;
  assign result.short_frame = o_short;

  `STKE_ASSERT_IMPLIES(a_pop_needs_head, clk, rst, pop, head_valid)
  `STKE_ASSERT_IMPLIES(a_head_has_work, clk, rst, head_valid && !head_short, remaining != '0)
  `STKE_ASSERT_IMPLIES(a_done_within_hits, clk, rst, head_valid, (done & ~head_ctl.hits) == '0)
  `STKE_ASSERT_IMPLIES(a_short_is_last, clk, rst, o_valid && o_short, o_last)
  `STKE_ASSERT_NEXT(a_pop_clears_done, clk, rst, pop, done == '0)
endmodule
`default_nettype wire

// ===== rtl/smooth_teager_kaiser_energy.sv =====
`timescale 1ns / 1ps
`default_nettype none
// throughput: one sample word per cycle while the four-entry job queue is not full; a
//   frame end word flushes up to six results, issued by the back end one per cycle while
//   the result side accepts them, and the job queue keeps taking words meanwhile
// reset: synchronous, clears the window, position and phase counters, the job queue and
//   all pipeline valids, and returns the decimation step to one; no clearing pass
module smooth_teager_kaiser_energy #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_STEP    = 4096
) (
  input  logic          clk,
  input  logic          rst,
  stke_sample_if.sink   feed,
  stke_cfg_if.sink      cfg,
  stke_result_if.source result
);
  // one queued job: control fields on top, window snapshot below
  localparam int CTLW  = $bits(stke_pkg::job_ctl_t);
  localparam int WINW  = stke_pkg::WIN_LEN * SAMPLE_BITS;
  localparam int JOBW  = CTLW + WINW;

  logic                                          q_full;
  logic                                          push;
  logic                                          pop;
  logic                                          head_valid;
  stke_pkg::job_ctl_t                            push_ctl;
  stke_pkg::job_ctl_t                            head_ctl;
  logic [stke_pkg::WIN_LEN-1:0][SAMPLE_BITS-1:0] push_win;
  logic [stke_pkg::WIN_LEN-1:0][SAMPLE_BITS-1:0] head_win;
  logic [JOBW-1:0]                               push_data;
  logic [JOBW-1:0]                               head_data;

  // front: sample window, frame position, decimation phase, job classification
  stke_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_STEP    (MAX_STEP)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .feed     (feed),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .push_ctl (push_ctl),
    .push_win (push_win)
  );

  assign push_data = {push_ctl, push_win};

  // short job queue, decouples sample intake from result drain
  stke_queue #(
    .WIDTH (JOBW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign head_ctl = stke_pkg::job_ctl_t'(head_data[JOBW-1 -: CTLW]);
  assign head_win = head_data[WINW-1:0];

  // back: mirrored tap selection, sums, square and cross products, output register
  stke_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_ctl   (head_ctl),
    .head_win   (head_win),
    .pop        (pop),
    .result     (result)
  );
endmodule
`default_nettype wire
